// File: rtl/core/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round-sum helper for the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned ROUNDS   = 32;
    localparam int unsigned STAGES   = 2 * ROUNDS;  // one half-round per stage
    localparam logic [31:0] DELTA    = 32'h9E37_79B9;
    localparam logic [31:0] DEC_SUM  = 32'hC6EF_3720;

    // config register map
    localparam logic [1:0] REG_KEY_A = 2'd0;
    localparam logic [1:0] REG_KEY_B = 2'd1;
    localparam logic [1:0] REG_KEY_C = 2'd2;
    localparam logic [1:0] REG_KEY_D = 2'd3;

    typedef enum logic {
        DIR_ENC = 1'b0,
        DIR_DEC = 1'b1
    } tea_dir_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } tea_key_t;

    // block in flight through the round pipeline
    typedef struct packed {
        tea_dir_t    dir;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } tea_word_t;

    // finished block toward the output buffer
    typedef struct packed {
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } tea_beat_t;

    // n * delta, modulo 2^32
    function automatic logic [31:0] round_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(n) * 64'(DELTA);
        return prod[31:0];
    endfunction

endpackage

// File: rtl/core/tea_stage.sv
// ----------------------------------------------------------------------------
// tea_stage
// One half-round of TEA: updates one word of the block and registers it.
// ----------------------------------------------------------------------------
module tea_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  tea_pkg::tea_key_t  key,
    input  logic               valid_in,
    input  tea_pkg::tea_word_t data_in,
    output logic               valid_out,
    output tea_pkg::tea_word_t data_out
);

    localparam int unsigned ROUND = STAGE / 2;
    localparam bit          HALF  = (STAGE % 2) != 0;
    localparam logic [31:0] SUM_ENC = tea_pkg::round_sum(ROUND + 1);
    localparam logic [31:0] SUM_DEC = tea_pkg::DEC_SUM - tea_pkg::round_sum(ROUND);

    logic               valid_reg;
    tea_pkg::tea_word_t data_reg;
    tea_pkg::tea_word_t data_next;

    logic        upd_y;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] k_hi;
    logic [31:0] k_lo;
    logic [31:0] sum;
    logic [31:0] mix;
    logic [31:0] res;

    always_comb begin
        // encipher: y then z; decipher: z then y
        upd_y = (data_in.dir == tea_pkg::DIR_ENC) ? !HALF : HALF;
        src   = upd_y ? data_in.z : data_in.y;
        dst   = upd_y ? data_in.y : data_in.z;
        k_hi  = upd_y ? key.a : key.c;
        k_lo  = upd_y ? key.b : key.d;
        sum   = (data_in.dir == tea_pkg::DIR_ENC) ? SUM_ENC : SUM_DEC;
        mix   = ((src << 4) + k_hi) ^ (src + sum) ^ ((src >> 5) + k_lo);
        res   = (data_in.dir == tea_pkg::DIR_ENC) ? dst + mix : dst - mix;

        data_next = data_in;
        if (upd_y) begin
            data_next.y = res;
        end else begin
            data_next.z = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// File: rtl/core/tea_skid.sv
// ----------------------------------------------------------------------------
// tea_skid
// Output register with a skid slot; keeps the pipeline moving under backpressure.
// ----------------------------------------------------------------------------
module tea_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tea_pkg::tea_beat_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tea_pkg::tea_beat_t out_data
);

    logic               out_valid_reg;
    tea_pkg::tea_beat_t out_data_reg;
    logic               skid_valid_reg;
    tea_pkg::tea_beat_t skid_data_reg;

    logic take;
    logic in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign take     = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA 64-bit block cipher, 128-bit key, 32 rounds, ECB, fully pipelined.
// ----------------------------------------------------------------------------
// Datapath: each input beat passes the 64 half-round stage registers and then
// the output register.
// Throughput: one block per cycle while the pipeline is not stalled; each of the 64 stages does one half-round.
// Reset: aresetn synchronous, active low; clears the key words to zero and
// all valid bits. Data registers are not reset.
// ----------------------------------------------------------------------------
module tea_block_cipher (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,

    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] block_left, [63:32] block_right
    input  logic        s_tuser,   // kind: 0 encipher, 1 decipher
    input  logic        s_tlast,   // last_block

    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] result_left, [63:32] result_right
    output logic        m_tlast    // result_last
);

    localparam int unsigned NSTG = tea_pkg::STAGES;

    // key words; only to be written by the user while the pipeline is empty (not enforced here)
    tea_pkg::tea_key_t key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tea_pkg::REG_KEY_A: key_reg.a <= cfg_wdata;
                tea_pkg::REG_KEY_B: key_reg.b <= cfg_wdata;
                tea_pkg::REG_KEY_C: key_reg.c <= cfg_wdata;
                tea_pkg::REG_KEY_D: key_reg.d <= cfg_wdata;
                default:            key_reg   <= key_reg;
            endcase
        end
    end

    // whole pipeline advances together; it stops only when the skid slot
    // holds a beat
    logic pipe_en;

    logic               stg_valid [0:NSTG];
    tea_pkg::tea_word_t stg_data  [0:NSTG];

    assign s_tready     = pipe_en;
    assign stg_valid[0] = s_tvalid;
    assign stg_data[0]  = {tea_pkg::tea_dir_t'(s_tuser), s_tdata[31:0], s_tdata[63:32],
                           s_tlast};

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        tea_stage #(
            .STAGE (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .key       (key_reg),
            .valid_in  (stg_valid[g]),
            .data_in   (stg_data[g]),
            .valid_out (stg_valid[g+1]),
            .data_out  (stg_data[g+1])
        );
    end

    tea_pkg::tea_beat_t tail_beat;
    tea_pkg::tea_beat_t out_beat;

    always_comb begin
        tail_beat.y    = stg_data[NSTG].y;
        tail_beat.z    = stg_data[NSTG].z;
        tail_beat.last = stg_data[NSTG].last;
    end

    tea_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[NSTG]),
        .in_ready  (pipe_en),
        .in_data   (tail_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_beat)
    );

    assign m_tdata = {out_beat.z, out_beat.y};
    assign m_tlast = out_beat.last;

endmodule
